>>> design/rotate_project_point_top_assert.svh
// assertion macros for the projection pipeline
`ifndef ROTATE_PROJECT_POINT_TOP_ASSERT_SVH
`define ROTATE_PROJECT_POINT_TOP_ASSERT_SVH

// a source pulse is followed by the strobe a fixed number of cycles later
`define RPP_ASSERT_DELAYED(label, clk, rst_n, sig, src, dly) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (src) |-> ##(dly) (sig)) \
    else $error("delayed strobe mismatch");

// a condition implies another in the same cycle
`define RPP_ASSERT_IMPLIES(label, clk, rst_n, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error("implication violated");

`endif

>>> design/rpp_pkg.sv
`timescale 1ns / 1ps
package rpp_pkg;

  // cordic datapath width, q2.30 plus guard bits
  localparam int CORDIC_W = 34;
  localparam int ATAN_LEN = 24;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_U = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_V = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_U   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_V   = 3'd3;

  localparam logic [23:0] GAIN_RESET = 24'd65536;

  typedef struct packed {
    logic        [15:0] turn_angle;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pixel_u;
    logic signed [15:0] pixel_v;
  } out_item_t;

  // one beat travelling down the cordic chain
  typedef struct packed {
    logic                       valid;
    logic                       flip;
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
    logic signed [31:0]         pos_x;
    logic signed [31:0]         pos_y;
    logic signed [31:0]         pos_z;
  } cordic_beat_t;

  // arctangent of 2^-i in 32-bit turn units
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] a;
    unique case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // q32 value to pixel: round half up, saturate to 16 bits signed
  function automatic logic signed [15:0] sat_pixel(input logic signed [63:0] q);
    logic signed [63:0] r;
    logic signed [63:0] t;
    logic signed [15:0] p;
    r = q + 64'sd2147483648;
    t = r >>> 32;
    if (t > 64'sd32767) begin
      p = 16'sh7FFF;
    end else if (t < -64'sd32768) begin
      p = 16'sh8000;
    end else begin
      p = t[15:0];
    end
    return p;
  endfunction

endpackage

>>> design/rpp_prep.sv
`timescale 1ns / 1ps
module rpp_prep #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  rpp_pkg::in_item_t      item,
  output rpp_pkg::cordic_beat_t  beat_out
);

  localparam logic [31:0] ANGLE_KEEP = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  logic [31:0]           ang;
  logic                  flip;
  logic [31:0]           ang_fold;
  rpp_pkg::cordic_beat_t beat_nxt;
  rpp_pkg::cordic_beat_t beat_r;

  always_comb begin
    ang      = {item.turn_angle, 16'h0000} & ANGLE_KEEP;
    // left half plane: bit 31 of (ang + quarter turn)
    flip     = ang[31] ^ ang[30];
    ang_fold = flip ? {~ang[31], ang[30:0]} : ang;
    beat_nxt.valid = fire;
    beat_nxt.flip  = flip;
    beat_nxt.x     = rpp_pkg::CORDIC_X0;
    beat_nxt.y     = '0;
    beat_nxt.z     = {{(rpp_pkg::CORDIC_W - 32){ang_fold[31]}}, ang_fold};
    beat_nxt.pos_x = item.pos_x;
    beat_nxt.pos_y = item.pos_y;
    beat_nxt.pos_z = item.pos_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else begin
      beat_r <= beat_nxt;
    end
  end

  assign beat_out = beat_r;

endmodule

>>> design/rpp_cordic_stage.sv
`timescale 1ns / 1ps
module rpp_cordic_stage #(
  parameter int STAGE_IDX = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rpp_pkg::cordic_beat_t  beat_in,
  output rpp_pkg::cordic_beat_t  beat_out
);

  logic signed [rpp_pkg::CORDIC_W-1:0] dx;
  logic signed [rpp_pkg::CORDIC_W-1:0] dy;
  logic signed [rpp_pkg::CORDIC_W-1:0] da;
  rpp_pkg::cordic_beat_t               beat_nxt;
  rpp_pkg::cordic_beat_t               beat_r;

  always_comb begin
    dx = beat_in.y >>> STAGE_IDX;
    dy = beat_in.x >>> STAGE_IDX;
    da = $signed({{(rpp_pkg::CORDIC_W - 32){1'b0}}, rpp_pkg::atan_turn(5'(STAGE_IDX))});
    beat_nxt = beat_in;
    // rotate towards zero residual angle
    if (!beat_in.z[rpp_pkg::CORDIC_W-1]) begin
      beat_nxt.x = beat_in.x - dx;
      beat_nxt.y = beat_in.y + dy;
      beat_nxt.z = beat_in.z - da;
    end else begin
      beat_nxt.x = beat_in.x + dx;
      beat_nxt.y = beat_in.y - dy;
      beat_nxt.z = beat_in.z + da;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else begin
      beat_r <= beat_nxt;
    end
  end

  assign beat_out = beat_r;

endmodule

>>> design/rpp_project.sv
`timescale 1ns / 1ps
module rpp_project (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rpp_pkg::cordic_beat_t  beat_in,
  input  logic [15:0]            centre_u,
  input  logic [15:0]            centre_v,
  input  logic [23:0]            gain_u,
  input  logic [23:0]            gain_v,
  output logic                   out_strobe,
  output rpp_pkg::out_item_t     out_item
);

  logic signed [rpp_pkg::CORDIC_W-1:0] cs_full;
  logic signed [rpp_pkg::CORDIC_W-1:0] sn_full;
  logic signed [31:0] cs;
  logic signed [31:0] sn;
  logic signed [64:0] diff;

  // stage 1: products
  logic               v1_r;
  logic signed [63:0] cy_r;
  logic signed [63:0] sz_r;
  logic signed [56:0] pu1_r;
  // stage 2: rotated y in q16.16
  logic               v2_r;
  logic signed [34:0] yr_r;
  logic signed [56:0] pu2_r;
  // stage 3: v product, u pixel
  logic               v3_r;
  logic signed [59:0] pv_r;
  logic signed [15:0] pix_u3_r;
  // stage 4: v pixel
  logic               v4_r;
  logic signed [15:0] pix_u4_r;
  logic signed [15:0] pix_v4_r;

  always_comb begin
    cs_full = beat_in.flip ? -beat_in.x : beat_in.x;
    sn_full = beat_in.flip ? -beat_in.y : beat_in.y;
    cs      = cs_full[31:0];
    sn      = sn_full[31:0];
    diff    = 65'(cy_r) - 65'(sz_r) + 65'sd536870912;
  end

  always_ff @(posedge clk) begin
    cy_r     <= cs * beat_in.pos_y;
    sz_r     <= sn * beat_in.pos_z;
    pu1_r    <= beat_in.pos_x * $signed({1'b0, gain_u});
    yr_r     <= diff[64:30];
    pu2_r    <= pu1_r;
    pv_r     <= yr_r * $signed({1'b0, gain_v});
    pix_u3_r <= rpp_pkg::sat_pixel(64'(pu2_r) + $signed({16'h0000, centre_u, 32'h0}));
    pix_u4_r <= pix_u3_r;
    pix_v4_r <= rpp_pkg::sat_pixel(64'(pv_r) + $signed({16'h0000, centre_v, 32'h0}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= beat_in.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign out_strobe       = v4_r;
  assign out_item.pixel_u = pix_u4_r;
  assign out_item.pixel_v = pix_v4_r;

endmodule

>>> design/rotate_project_point_top.sv
`timescale 1ns / 1ps
// path from start to out_strobe: prep register, cordic stage registers, four projection stages
// throughput: one point per cycle, set by the fully unrolled cordic and product pipeline
// busy is high only while rst_n is low; the receiver cannot stall, so nothing holds the pipe
// reset: synchronous, active low; clears the valid bits, centres to 0 and gains to 1.0
`include "rotate_project_point_top_assert.svh"
module rotate_project_point_top #(
  parameter int CORDIC_STAGES = 16,
  parameter int ANGLE_BITS    = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input beats
  input  logic                              start,
  output logic                              busy,
  input  rpp_pkg::in_item_t                 in_item,
  // result beats
  output logic                              out_strobe,
  output rpp_pkg::out_item_t                out_item,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rpp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rpp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // the arctangent table runs out after its last entry
  localparam int NUM_STAGES = (CORDIC_STAGES < rpp_pkg::ATAN_LEN) ?
                              CORDIC_STAGES : rpp_pkg::ATAN_LEN;
  // prep register, cordic stages, four projection stages
  localparam int LATENCY    = NUM_STAGES + 5;
  localparam int PROJ_LAT   = 4;

  logic        in_fire;
  logic [15:0] centre_u_r;
  logic [15:0] centre_v_r;
  logic [23:0] gain_u_r;
  logic [23:0] gain_v_r;

  rpp_pkg::cordic_beat_t beat_w [NUM_STAGES+1];

  // no back-pressure anywhere, the pipe only refuses beats in reset
  assign busy      = ~rst_n;
  assign in_fire   = start & ~busy;
  assign cfg_ready = 1'b1;

  // camera registers; writes to unknown indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_u_r <= '0;
      centre_v_r <= '0;
      gain_u_r   <= rpp_pkg::GAIN_RESET;
      gain_v_r   <= rpp_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rpp_pkg::REG_CENTRE_U: centre_u_r <= cfg_data[15:0];
        rpp_pkg::REG_CENTRE_V: centre_v_r <= cfg_data[15:0];
        rpp_pkg::REG_GAIN_U:   gain_u_r   <= cfg_data;
        rpp_pkg::REG_GAIN_V:   gain_v_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // angle masking, half-turn fold and cordic seed
  rpp_prep #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (in_fire),
    .item     (in_item),
    .beat_out (beat_w[0])
  );

  // one registered micro-rotation per stage, point coordinates ride along
  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cordic
    rpp_cordic_stage #(
      .STAGE_IDX (g)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .beat_in  (beat_w[g]),
      .beat_out (beat_w[g+1])
    );
  end

  // rotation of y, camera gains, centre offsets, rounding and saturation
  rpp_project u_project (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_in    (beat_w[NUM_STAGES]),
    .centre_u   (centre_u_r),
    .centre_v   (centre_v_r),
    .gain_u     (gain_u_r),
    .gain_v     (gain_v_r),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // every accepted beat comes out after the fixed latency
  `RPP_ASSERT_DELAYED(a_end_to_end, clk, rst_n, out_strobe, in_fire, LATENCY)
  // and no result turns up without a beat accepted that long before
  `RPP_ASSERT_IMPLIES(a_no_stray, clk, rst_n, out_strobe, $past(in_fire, LATENCY))
  // the projection section keeps its own depth
  `RPP_ASSERT_DELAYED(a_proj_depth, clk, rst_n, out_strobe, beat_w[NUM_STAGES].valid, PROJ_LAT)
  // a beat leaving the cordic chain left the prep register the right number of cycles before
  `RPP_ASSERT_IMPLIES(a_cordic_depth, clk, rst_n, beat_w[NUM_STAGES].valid, $past(beat_w[0].valid, NUM_STAGES))

endmodule

>>> dv/tb_rotate_project_point_top.sv
`timescale 1ns / 1ps
module tb_rotate_project_point_top;

  // pipeline shape, kept equal to the block's defaults
  localparam int N_STAGES     = 16;
  localparam int N_ANGLE_BITS = 16;
  localparam int PIPE_LATENCY = N_STAGES + 5;
  localparam int RANDOM_PHASES = 8;
  localparam int POINTS_PER_PHASE = 250;

  // register indexes beyond the last real register are spare and must be ignored
  localparam logic [rpp_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = rpp_pkg::REG_GAIN_V + 3'd1;
  localparam logic [rpp_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

  localparam logic [23:0] GAIN_MAX   = 24'hFFFFFF;
  localparam logic [15:0] CENTRE_MAX = 16'hFFFF;

  // expected pixel store plus its own projection predictor and register shadow
  class pixel_checker;
    longint              atan_tab[24];
    int                  stages;
    int                  angle_bits;
    logic [15:0]         centre_u;
    logic [15:0]         centre_v;
    logic [23:0]         gain_u;
    logic [23:0]         gain_v;
    rpp_pkg::out_item_t  expected_pixels[$];
    int                  mismatch_count;

    function new(int n_stages, int n_angle_bits);
      stages     = n_stages;
      angle_bits = n_angle_bits;
      // arctan(2^-i) in 32-bit turn units
      atan_tab = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
      };
      centre_u       = '0;
      centre_v       = '0;
      gain_u         = rpp_pkg::GAIN_RESET;
      gain_v         = rpp_pkg::GAIN_RESET;
      mismatch_count = 0;
    endfunction

    function void write_reg(logic [rpp_pkg::CFG_IDX_W-1:0] idx,
                            logic [rpp_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        rpp_pkg::REG_CENTRE_U: centre_u = data[15:0];
        rpp_pkg::REG_CENTRE_V: centre_v = data[15:0];
        rpp_pkg::REG_GAIN_U:   gain_u   = data[23:0];
        rpp_pkg::REG_GAIN_V:   gain_v   = data[23:0];
        default: ;
      endcase
    endfunction

    // q32 to pixel, round half up then clamp
    function logic signed [15:0] to_pixel(longint q);
      longint r;
      r = (q + 64'sd2147483648) >>> 32;
      if (r > 64'sd32767) return 16'sh7FFF;
      if (r < -64'sd32768) return 16'sh8000;
      return r[15:0];
    endfunction

    function rpp_pkg::out_item_t project_point(rpp_pkg::in_item_t pt);
      logic [31:0]        ang;
      logic [31:0]        shifted;
      logic               flip;
      longint             cx, cy, cz, dx, dy;
      longint             px, py, pz, y_cam, q_u, q_v;
      rpp_pkg::out_item_t res;
      // drop angle bits below the resolution, fold the left half plane
      ang = {pt.turn_angle, 16'h0000} & ~((32'h1 << (32 - angle_bits)) - 32'h1);
      shifted = ang + 32'h4000_0000;
      flip = shifted[31];
      if (flip) ang = ang + 32'h8000_0000;
      cz = longint'($signed(ang));
      cx = 64'sd652032874;
      cy = 0;
      for (int i = 0; i < stages && i < 24; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cz >= 0) begin
          cx = cx - dx;
          cy = cy + dy;
          cz = cz - atan_tab[i];
        end else begin
          cx = cx + dx;
          cy = cy - dy;
          cz = cz + atan_tab[i];
        end
      end
      if (flip) begin
        cx = -cx;
        cy = -cy;
      end
      px = longint'($signed(pt.pos_x));
      py = longint'($signed(pt.pos_y));
      pz = longint'($signed(pt.pos_z));
      // rotated y in q16.16, cos and sin being q2.30
      y_cam = (cx * py - cy * pz + 64'sd536870912) >>> 30;
      q_u = px * longint'({40'h0, gain_u}) + (longint'({48'h0, centre_u}) <<< 32);
      q_v = y_cam * longint'({40'h0, gain_v}) + (longint'({48'h0, centre_v}) <<< 32);
      res.pixel_u = to_pixel(q_u);
      res.pixel_v = to_pixel(q_v);
      return res;
    endfunction

    function void note_point(rpp_pkg::in_item_t pt);
      expected_pixels.push_back(project_point(pt));
    endfunction

    function void check_pixel(rpp_pkg::out_item_t got);
      rpp_pkg::out_item_t want;
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual u=%0d v=%0d",
                 $time, got.pixel_u, got.pixel_v);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_u !== want.pixel_u) begin
        mismatch_count++;
        $display("%0t: pixel_u mismatch, expected %0d, actual %0d",
                 $time, want.pixel_u, got.pixel_u);
      end
      if (got.pixel_v !== want.pixel_v) begin
        mismatch_count++;
        $display("%0t: pixel_v mismatch, expected %0d, actual %0d",
                 $time, want.pixel_v, got.pixel_v);
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  rpp_pkg::in_item_t              in_item;
  logic                           out_strobe;
  rpp_pkg::out_item_t             out_item;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [rpp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rpp_pkg::CFG_DATA_W-1:0] cfg_data;

  pixel_checker pixels = new(N_STAGES, N_ANGLE_BITS);

  rotate_project_point_top #(
    .CORDIC_STAGES(N_STAGES),
    .ANGLE_BITS   (N_ANGLE_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the pipe hangs; a correct run needs well under a tenth of this
  initial begin
    #5_000_000;
    $display("tb_rotate_project_point_top: FAIL");
    $finish;
  end

  // everything is sampled on the rising edge, before the block's flops update
  always @(posedge clk) begin
    if (rst_n) begin
      // a result is offered for one cycle only, so check it on the spot
      if (out_strobe) pixels.check_pixel(out_item);
      // accepted input beat gets its prediction queued
      if (start && !busy) pixels.note_point(in_item);
      // register write takes effect for every later beat
      if (cfg_valid && cfg_ready) pixels.write_reg(cfg_index, cfg_data);
    end
  end

  // one input beat: optional idle gap, then hold start until busy is seen low
  task automatic send_point(rpp_pkg::in_item_t pt, int unsigned gap);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      // junk on the bus while idle, must not be picked up
      in_item = {16'($urandom), $urandom, $urandom, $urandom};
      repeat (gap) @(negedge clk);
    end
    start   = 1'b1;
    in_item = pt;
    do @(posedge clk); while (busy);
  endtask

  // park the input side low
  task automatic stop_points();
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic write_reg(logic [rpp_pkg::CFG_IDX_W-1:0] idx,
                           logic [rpp_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait for every expected pixel, then watch on for strays
  task automatic drain_pixels();
    while (pixels.expected_pixels.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LATENCY) @(posedge clk);
  endtask

  // mostly modest coordinates so results stay in the pixel range, some full scale
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0, 1:    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      2:       return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    // quadrant edges now and then, where the half-plane fold switches
    if ($urandom_range(0, 7) == 0)
      return {2'($urandom_range(0, 3)), 14'h0000} + 16'($signed($urandom_range(0, 4)) - 2);
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic run_directed();
    rpp_pkg::in_item_t pts[$];
    rpp_pkg::in_item_t pt;
    // angle sweep across the quadrant edges and the top of the range
    pts.push_back('{16'h0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0000_0000});
    pts.push_back('{16'h3FFF, 32'sh0000_0000, 32'sh000A_0000, 32'sh0005_0000});
    pts.push_back('{16'h4000, 32'sh0000_0000, 32'sh000A_0000, 32'sh0005_0000});
    pts.push_back('{16'h4001, 32'sh0000_0000, 32'sh000A_0000, 32'sh0005_0000});
    pts.push_back('{16'h8000, 32'sh0002_0000, 32'sh0007_0000, -32'sh0003_0000});
    pts.push_back('{16'hBFFF, -32'sh0002_0000, 32'sh0007_0000, -32'sh0003_0000});
    pts.push_back('{16'hC000, -32'sh0002_0000, 32'sh0007_0000, -32'sh0003_0000});
    pts.push_back('{16'hC001, 32'sh0000_0001, -32'sh0000_0001, 32'sh0000_0001});
    pts.push_back('{16'hFFFF, 32'sh0040_0000, -32'sh0040_0000, 32'sh0040_0000});
    pts.push_back('{16'h2000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000});
    // rounding right on the half pixel, both signs
    pts.push_back('{16'h0000, 32'sh0000_8000, 32'sh0000_8000, 32'sh0000_0000});
    pts.push_back('{16'h0000, -32'sh0000_8000, -32'sh0000_8000, 32'sh0000_0000});
    pts.push_back('{16'h0000, 32'sh0000_7FFF, -32'sh0000_8001, 32'sh0000_0000});
    // coordinates at the rails, must saturate rather than wrap
    pts.push_back('{16'h0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
    pts.push_back('{16'h8000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
    pts.push_back('{16'h4000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
    pts.push_back('{16'hC000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000});
    // just inside and just outside the pixel range at unit gain
    pts.push_back('{16'h0000, 32'sh7FFF_0000, 32'sh7FFF_7FFF, 32'sh0000_0000});
    pts.push_back('{16'h0000, -32'sh8000_0000, -32'sh8000_8001, 32'sh0000_0000});
    pts.push_back('{16'h0000, 32'sh7FFF_8000, 32'sh8000_7FFF, 32'sh0000_0000});
    foreach (pts[i]) begin
      pt = pts[i];
      // first half back to back, second half with gaps
      send_point(pt, (i < 10) ? 0 : $urandom_range(0, 6));
    end
    stop_points();
  endtask

  // register set for one phase; phases 0 and 1 pin the extremes, phase 2 sets unit gains
  task automatic configure_phase(int phase);
    logic [23:0] gu, gv;
    logic [23:0] cu, cv;
    case (phase)
      0: begin
        gu = '0; gv = '0; cu = '0; cv = '0;
      end
      1: begin
        gu = GAIN_MAX; gv = GAIN_MAX; cu = {8'h00, CENTRE_MAX}; cv = {8'h00, CENTRE_MAX};
      end
      2: begin
        gu = rpp_pkg::GAIN_RESET; gv = rpp_pkg::GAIN_RESET; cu = 24'd32000; cv = 24'd16000;
      end
      default: begin
        gu = 24'($urandom_range(0, 24'h04_0000));
        gv = 24'($urandom_range(0, 24'h04_0000));
        // upper data bits are junk for the 16-bit centre registers
        cu = {8'($urandom_range(0, 8'hFF)), 16'($urandom_range(0, 1024))};
        cv = {8'($urandom_range(0, 8'hFF)), 16'($urandom_range(0, 1024))};
      end
    endcase
    write_reg(rpp_pkg::REG_GAIN_U, gu);
    write_reg(rpp_pkg::REG_GAIN_V, gv);
    write_reg(rpp_pkg::REG_CENTRE_U, cu);
    write_reg(rpp_pkg::REG_CENTRE_V, cv);
    // spare index, must leave every register alone
    write_reg(rpp_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
              rpp_pkg::CFG_DATA_W'($urandom));
  endtask

  task automatic run_random(int phase);
    rpp_pkg::in_item_t pt;
    bit                back_to_back;
    // every third phase runs without gaps; others also get short gapless bursts
    back_to_back = (phase % 3 == 0);
    for (int n = 0; n < POINTS_PER_PHASE; n++) begin
      pt.turn_angle = rand_angle();
      pt.pos_x      = rand_coord();
      pt.pos_y      = rand_coord();
      pt.pos_z      = rand_coord();
      if (back_to_back || (n % 40) < 10) send_point(pt, 0);
      else send_point(pt, $urandom_range(0, 6));
    end
    stop_points();
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // reset defaults first: unit gains, zero centres
    run_directed();
    drain_pixels();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      configure_phase(phase);
      // the first few settings also see the hand-picked points
      if (phase < 3) begin
        run_directed();
        drain_pixels();
      end
      run_random(phase);
      drain_pixels();
    end

    // anything still waiting here never came out
    if (pixels.expected_pixels.size() != 0) begin
      pixels.mismatch_count++;
      $display("%0t: %0d expected results never arrived", $time,
               pixels.expected_pixels.size());
    end

    if (pixels.mismatch_count == 0) begin
      $display("tb_rotate_project_point_top: PASS");
    end else begin
      $display("tb_rotate_project_point_top: FAIL");
    end
    $finish;
  end

endmodule

>>> rotate_project_point_top.f
+incdir+design
design/rpp_pkg.sv
design/rpp_prep.sv
design/rpp_cordic_stage.sv
design/rpp_project.sv
design/rotate_project_point_top.sv
dv/tb_rotate_project_point_top.sv
